FILE: design/rsw_pkg.sv
// ---------------------------------------------------------------------------
// rsw_pkg: shared types and constants
// Request and result structs, controller command and status groups.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsw_pkg;

    localparam int FRAC_BITS = 10;
    localparam logic [62:0] M2_MAX = {63{1'b1}};
    localparam logic [62:0] M2_RND = 63'(1 << (FRAC_BITS - 1));
    localparam logic [30:0] VAR_MAX = {31{1'b1}};
    localparam logic [6:0] DIV1_ITERS = 7'd43;
    localparam logic [6:0] DIV2_ITERS = 7'd63;

    typedef struct packed {
        logic               func;
        logic signed [31:0] sample;
    } req_t;

    typedef struct packed {
        logic [31:0]        sample_count;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic signed [31:0] mean_value;
        logic [30:0]        variance_q10;
    } res_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic bump;
        logic div1_start;
        logic mean_upd;
        logic d2_set;
        logic mul_step;
        logic sat;
        logic acc;
        logic div2_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic full;
        logic empty;
        logic div_done;
        logic mul_last;
    } stat_t;

endpackage

`default_nettype wire

FILE: design/rsw_div.sv
// ---------------------------------------------------------------------------
// rsw_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, dividend taken MSB first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsw_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    input  wire logic [6:0]  iters,
    output logic             done,
    output logic [63:0]      quot
);

    logic        run_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [63:0] quot_reg;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, num_reg[63]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= iters;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg  <= {num_reg[62:0], 1'b0};
            rem_reg  <= ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

FILE: design/rsw_datapath.sv
// ---------------------------------------------------------------------------
// rsw_datapath: statistics state and arithmetic
// Welford update, byte-serial multiplier, shared divider and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsw_datapath #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rsw_pkg::req_t req,
    input  wire rsw_pkg::cmd_t cmd,
    output rsw_pkg::stat_t     stat,
    output rsw_pkg::res_t      res
);

    logic [31:0]        count_reg;
    logic signed [41:0] mean_reg;
    logic [62:0]        m2_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;

    logic               func_reg;
    logic signed [31:0] v_reg;
    logic               d1_neg_reg;
    logic [42:0]        d1_mag_reg;
    logic [47:0]        b_reg;
    logic [2:0]         mul_cnt_reg;
    logic [85:0]        acc_reg;
    logic [62:0]        x_reg;
    rsw_pkg::res_t      res_reg;

    logic signed [SAMPLE_BITS-1:0] s_low;
    logic signed [41:0] vs;
    logic signed [42:0] d1;
    logic signed [42:0] d2;
    logic signed [42:0] q_s;
    logic signed [42:0] mean_sum;
    logic [62:0]        prod;
    logic [63:0]        m2_sum;
    logic [63:0]        num2;
    logic               ovf;
    logic [42:0]        mean_abs;
    logic [32:0]        mean_rnd;
    logic [31:0]        mean_out;
    logic [30:0]        var_out;

    logic        div_start;
    logic [63:0] div_num;
    logic [6:0]  div_iters;
    logic        div_done;
    logic [63:0] div_quot;

    assign s_low    = req.sample[SAMPLE_BITS-1:0];
    assign vs       = {v_reg, 10'b0};
    assign d1       = 43'(vs) - 43'(mean_reg);
    assign d2       = 43'(vs) - 43'(mean_reg);
    assign q_s      = d1_neg_reg ? -$signed(div_quot[42:0]) : $signed(div_quot[42:0]);
    assign mean_sum = 43'(mean_reg) + q_s;
    assign prod     = (|acc_reg[85:63]) ? rsw_pkg::M2_MAX : acc_reg[62:0];
    assign m2_sum   = 64'(m2_reg) + 64'(x_reg);
    assign num2     = 64'(m2_reg) + 64'(count_reg[31:1]);
    assign ovf      = num2[63];
    assign mean_abs = mean_reg[41] ? -43'(mean_reg) : 43'(mean_reg);
    assign mean_rnd = 33'((mean_abs + 43'd512) >> rsw_pkg::FRAC_BITS);
    assign mean_out = mean_reg[41] ? -mean_rnd[31:0] : mean_rnd[31:0];

    always_comb
    begin
        if (count_reg == '0)
            var_out = '0;
        else if (ovf || (|div_quot[63:31]))
            var_out = rsw_pkg::VAR_MAX;
        else
            var_out = div_quot[30:0];
    end

    assign div_start = cmd.div1_start | cmd.div2_start;
    assign div_num   = cmd.div1_start ? {d1_mag_reg, 21'b0} : {num2[62:0], 1'b0};
    assign div_iters = cmd.div1_start ? rsw_pkg::DIV1_ITERS : rsw_pkg::DIV2_ITERS;

    rsw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (count_reg),
        .iters (div_iters),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            mean_reg  <= '0;
            m2_reg    <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            if (cmd.bump)
            begin
                count_reg <= count_reg + 32'd1;
                if (count_reg == '0)
                begin
                    min_reg <= v_reg;
                    max_reg <= v_reg;
                end
                else
                begin
                    if (v_reg < min_reg)
                        min_reg <= v_reg;
                    if (v_reg > max_reg)
                        max_reg <= v_reg;
                end
            end
            if (cmd.mean_upd)
                mean_reg <= mean_sum[41:0];
            if (cmd.acc)
                m2_reg <= m2_sum[63] ? rsw_pkg::M2_MAX : m2_sum[62:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= req.func;
            v_reg    <= 32'(s_low);
        end
        if (cmd.bump)
        begin
            d1_neg_reg <= d1[42];
            d1_mag_reg <= d1[42] ? 43'(-d1) : 43'(d1);
        end
        if (cmd.d2_set)
        begin
            b_reg       <= {5'b0, (d2[42] ? 43'(-d2) : 43'(d2))};
            mul_cnt_reg <= '0;
            acc_reg     <= '0;
        end
        else if (cmd.mul_step)
        begin
            b_reg       <= {b_reg[39:0], 8'b0};
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
            acc_reg     <= {acc_reg[77:0], 8'b0}
                           + 86'(51'(d1_mag_reg) * 51'(b_reg[47:40]));
        end
        if (cmd.sat)
            x_reg <= (prod > rsw_pkg::M2_MAX - rsw_pkg::M2_RND) ? rsw_pkg::M2_MAX
                     : 63'((64'(prod) + 64'(rsw_pkg::M2_RND)) >> rsw_pkg::FRAC_BITS);
        if (cmd.emit)
        begin
            res_reg.sample_count <= count_reg;
            res_reg.min_value    <= min_reg;
            res_reg.max_value    <= max_reg;
            res_reg.mean_value   <= mean_out;
            res_reg.variance_q10 <= var_out;
        end
    end

    assign stat.func     = func_reg;
    assign stat.full     = &count_reg;
    assign stat.empty    = count_reg == '0;
    assign stat.div_done = div_done;
    assign stat.mul_last = mul_cnt_reg == 3'd5;
    assign res           = res_reg;

endmodule

`default_nettype wire

FILE: design/rsw_ctrl.sv
// ---------------------------------------------------------------------------
// rsw_ctrl: sequencing state machine
// Steps the datapath through one request and owns both handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output logic                res_valid,
    input  wire logic           res_stall,
    input  wire rsw_pkg::stat_t stat,
    output rsw_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE  = 4'd1;
    localparam logic [3:0] S_D1S  = 4'd2;
    localparam logic [3:0] S_DIV1 = 4'd3;
    localparam logic [3:0] S_MUPD = 4'd4;
    localparam logic [3:0] S_D2   = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_SAT  = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_VST  = 4'd9;
    localparam logic [3:0] S_DIV2 = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       res_valid_reg;
    logic       slot_free;

    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PRE;
                end
            end
            S_PRE:
            begin
                if (stat.func)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_VST;
                end
                else if (stat.full)
                    state_next = S_VST;
                else
                begin
                    cmd.bump   = 1'b1;
                    state_next = S_D1S;
                end
            end
            S_D1S:
            begin
                cmd.div1_start = 1'b1;
                state_next     = S_DIV1;
            end
            S_DIV1:
            begin
                if (stat.div_done)
                    state_next = S_MUPD;
            end
            S_MUPD:
            begin
                cmd.mean_upd = 1'b1;
                state_next   = S_D2;
            end
            S_D2:
            begin
                cmd.d2_set = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_VST;
            end
            S_VST:
            begin
                if (stat.empty)
                    state_next = S_OUT;
                else
                begin
                    cmd.div2_start = 1'b1;
                    state_next     = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

FILE: design/running_stats_welford_q10.sv
// ---------------------------------------------------------------------------
// running_stats_welford_q10: streaming count, min, max, mean and variance
// Welford update in Q10 with saturating second moment.
// ---------------------------------------------------------------------------
//   channel   valid      stall      payload
//   request   req_valid  req_stall  req (func, sample)
//   result    res_valid  res_stall  res (count, min, max, mean, variance)
//
// A push passes through the two passes of the shared bit-serial divider and
// the byte-serial multiplier, which dominate its time. A push on a full count
// skips the update and runs only the variance division; a clear skips both.
// The controller returns to idle before the next request is taken.
// Reset clears all statistics. The next request is taken while a result
// still waits under res_stall; a result only leaves once the slot is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module running_stats_welford_q10 #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire rsw_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_stall,
    output rsw_pkg::res_t      res
);

    rsw_pkg::cmd_t  cmd;
    rsw_pkg::stat_t stat;

    rsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rsw_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

endmodule

`default_nettype wire
